FILE: src/pfc_pkg.sv
// Package: format codes and conversion helpers for the pixel format converter.
`timescale 1ns / 1ps
package pfc_pkg;

	typedef enum logic [2:0] {
		FMT_RGBA8  = 3'd0,
		FMT_BGRA8  = 3'd1,
		FMT_RGB8   = 3'd2,
		FMT_BGR8   = 3'd3,
		FMT_RGB565 = 3'd4,
		FMT_FLOAT  = 3'd5
	} fmt_t;

	// Register byte addresses
	localparam logic [2:0] ADDR_SRC = 3'd0;
	localparam logic [2:0] ADDR_DST = 3'd4;

	// Conversion route chosen per item
	typedef enum logic [2:0] {
		RT_UNSUP = 3'd0,
		RT_COPY  = 3'd1,
		RT_CONV  = 3'd2
	} route_t;

	// b/255 = b * 0.(00000001) repeating in binary; normalize and round to 24 bits
	function automatic logic [31:0] u8_div255(input logic [7:0] b);
		logic [63:0] q;
		logic [3:0]  lz;
		logic [63:0] n;
		logic [23:0] man;
		logic        rb;
		logic        st;
		logic [24:0] mr;
		logic [7:0]  ex;
		begin
			// b/255 * 2^64 approx: b * 0x0101..01 (exact repeating pattern, 8 copies)
			q = {56'd0, b} * 64'h0101010101010101;
			lz = 4'd0;
			for (int i = 0; i < 8; i++) begin
				if (q[63 - i] == 1'b0 && lz == 4'(i)) begin
					lz = 4'(i + 1);
				end
			end
			n = q << lz;
			man = n[63:40];
			rb = n[39];
			// Remainder never ties: the pattern is nonzero below any cut
			st = 1'b1;
			mr = {1'b0, man} + 25'(rb & (st | man[0]));
			ex = 8'd126 - 8'(lz);
			if (mr[24]) begin
				ex = ex + 8'd1;
				mr = mr >> 1;
			end
			u8_div255 = {1'b0, ex, mr[22:0]};
		end
	endfunction

	// Single-precision pattern of b/255, rounded to nearest
	function automatic logic [31:0] byte_to_float(input logic [7:0] b);
		logic [31:0] r;
		begin
			r = 32'd0;
			// Zero maps to +0; every other byte goes through the normalizer
			if (b != 8'd0) begin
				r = u8_div255(b);
			end
			byte_to_float = r;
		end
	endfunction

endpackage

FILE: src/pixel_format_converter.sv
// Top level: APB registers and a three-stage pixel conversion pipeline.
//
//  channel   signals                               direction
//  command   start, busy, in_ch0..3, in_last       in (busy is out)
//  result    done, out_ch0..3, out_status, out_last out
//  config    psel penable pwrite paddr pwdata ...  APB slave
//
// One item per cycle; each start passes through the v_s1, v_s2 and v_s3 valid registers to done.
// busy is always low; the receiver cannot stall, so nothing holds.
// Reset clears the valid bits and both format registers to RGBA8.
`timescale 1ns / 1ps
module pixel_format_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] in_ch0,
	input  logic [31:0] in_ch1,
	input  logic [31:0] in_ch2,
	input  logic [31:0] in_ch3,
	input  logic        in_last,
	output logic        done,
	output logic [31:0] out_ch0,
	output logic [31:0] out_ch1,
	output logic [31:0] out_ch2,
	output logic [31:0] out_ch3,
	output logic        out_status,
	output logic        out_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0] src_q;
	logic [2:0] dst_q;

	assign pready = 1'b1;
	assign busy   = 1'b0;

	// Write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= 3'd0;
			dst_q <= 3'd0;
		end else if (psel && penable && pwrite) begin
			if (paddr == pfc_pkg::ADDR_SRC) src_q <= pwdata[2:0];
			if (paddr == pfc_pkg::ADDR_DST) dst_q <= pwdata[2:0];
		end
	end

	always_comb begin
		case (paddr)
			pfc_pkg::ADDR_SRC: prdata = {29'd0, src_q};
			pfc_pkg::ADDR_DST: prdata = {29'd0, dst_q};
			default:           prdata = 32'd0;
		endcase
	end

	// Stage 1: choose route, register inputs
	pfc_pkg::route_t route;
	always_comb begin
		if (src_q > 3'(pfc_pkg::FMT_FLOAT) || dst_q > 3'(pfc_pkg::FMT_FLOAT)) begin
			route = pfc_pkg::RT_UNSUP;
		end else if (src_q == dst_q) begin
			route = pfc_pkg::RT_COPY;
		end else if (src_q == 3'(pfc_pkg::FMT_BGR8) || dst_q == 3'(pfc_pkg::FMT_BGR8) ||
			(src_q == 3'(pfc_pkg::FMT_BGRA8) && dst_q != 3'(pfc_pkg::FMT_RGBA8))) begin
			route = pfc_pkg::RT_UNSUP;
		end else begin
			route = pfc_pkg::RT_CONV;
		end
	end

	logic              v_s1, v_s2, v_s3;
	pfc_pkg::route_t   rt_s1, rt_s2;
	logic [2:0]        src_s1, dst_s1, dst_s2;
	logic [31:0]       c_s1 [4];
	logic              last_s1, last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		rt_s1   <= route;
		src_s1  <= src_q;
		dst_s1  <= dst_q;
		last_s1 <= in_last;
		c_s1[0] <= in_ch0;
		c_s1[1] <= in_ch1;
		c_s1[2] <= in_ch2;
		c_s1[3] <= in_ch3;
	end

	// Float-to-byte units span stages 1 and 2
	logic [7:0] fb_s2 [4];
	pfc_f2b u_f2b0 (.clk(clk), .bits(in_ch0), .byte_s2(fb_s2[0]));
	pfc_f2b u_f2b1 (.clk(clk), .bits(in_ch1), .byte_s2(fb_s2[1]));
	pfc_f2b u_f2b2 (.clk(clk), .bits(in_ch2), .byte_s2(fb_s2[2]));
	pfc_f2b u_f2b3 (.clk(clk), .bits(in_ch3), .byte_s2(fb_s2[3]));

	// Stage 2: integer sources to RGBA8; copy path masks
	logic [7:0]  rgba [4];
	logic [31:0] cp [4];
	logic [4:0]  r5, b5;
	logic [5:0]  g6;
	always_comb begin
		r5 = c_s1[0][15:11];
		g6 = c_s1[0][10:5];
		b5 = c_s1[0][4:0];
		for (int i = 0; i < 4; i++) begin
			rgba[i] = c_s1[i][7:0];
			cp[i]   = 32'd0;
		end
		case (src_s1)
			pfc_pkg::FMT_BGRA8: begin
				rgba[0] = c_s1[2][7:0];
				rgba[2] = c_s1[0][7:0];
			end
			pfc_pkg::FMT_RGB8: rgba[3] = 8'hFF;
			pfc_pkg::FMT_RGB565: begin
				rgba[0] = {r5, r5[4:2]};
				rgba[1] = {g6, g6[5:4]};
				rgba[2] = {b5, b5[4:2]};
				rgba[3] = 8'hFF;
			end
			default: ;
		endcase
		case (src_s1)
			pfc_pkg::FMT_RGBA8, pfc_pkg::FMT_BGRA8:
				for (int i = 0; i < 4; i++) cp[i] = {24'd0, c_s1[i][7:0]};
			pfc_pkg::FMT_RGB8, pfc_pkg::FMT_BGR8:
				for (int i = 0; i < 3; i++) cp[i] = {24'd0, c_s1[i][7:0]};
			pfc_pkg::FMT_RGB565: cp[0] = {16'd0, c_s1[0][15:0]};
			pfc_pkg::FMT_FLOAT:
				for (int i = 0; i < 4; i++) cp[i] = c_s1[i];
			default: ;
		endcase
	end

	logic [7:0]  rgba_s2 [4];
	logic [31:0] cp_s2 [4];
	logic        isf_s2;
	always_ff @(posedge clk) begin
		rt_s2   <= rt_s1;
		dst_s2  <= dst_s1;
		last_s2 <= last_s1;
		isf_s2  <= src_s1 == 3'(pfc_pkg::FMT_FLOAT);
		rgba_s2 <= rgba;
		cp_s2   <= cp;
	end

	// Stage 3: pack into the target format
	logic [7:0]  px [4];
	logic [31:0] res [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			px[i]  = isf_s2 ? fb_s2[i] : rgba_s2[i];
			res[i] = 32'd0;
		end
		if (rt_s2 == pfc_pkg::RT_COPY) begin
			res = cp_s2;
		end else if (rt_s2 == pfc_pkg::RT_CONV) begin
			case (dst_s2)
				pfc_pkg::FMT_RGBA8:
					for (int i = 0; i < 4; i++) res[i] = {24'd0, px[i]};
				pfc_pkg::FMT_BGRA8: begin
					res[0] = {24'd0, px[2]};
					res[1] = {24'd0, px[1]};
					res[2] = {24'd0, px[0]};
					res[3] = {24'd0, px[3]};
				end
				pfc_pkg::FMT_RGB8:
					for (int i = 0; i < 3; i++) res[i] = {24'd0, px[i]};
				pfc_pkg::FMT_RGB565:
					res[0] = {16'd0, px[0][7:3], px[1][7:2], px[2][7:3]};
				pfc_pkg::FMT_FLOAT:
					for (int i = 0; i < 4; i++) res[i] = pfc_pkg::byte_to_float(px[i]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		out_ch0    <= res[0];
		out_ch1    <= res[1];
		out_ch2    <= res[2];
		out_ch3    <= res[3];
		out_status <= rt_s2 == pfc_pkg::RT_UNSUP;
		out_last   <= last_s2;
	end

	assign done = v_s3;

	// Checks
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done) else $error("result missing");
	a_nostart: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start, 3) |-> !done) else $error("spurious result");
	a_unsup: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_status |-> out_ch0 == 32'd0 && out_ch3 == 32'd0)
		else $error("unsupported item carries data");

endmodule

FILE: src/pfc_f2b.sv
// Float channel to byte: clamp to [0,1] and truncate value*255, two stages.
`timescale 1ns / 1ps
module pfc_f2b (
	input  logic        clk,
	input  logic [31:0] bits,
	output logic [7:0]  byte_s2
);

	logic        sat_s1;
	logic        zero_s1;
	logic [23:0] man_s1;
	logic [4:0]  sh_s1;

	// Classify and align
	always_ff @(posedge clk) begin
		sat_s1  <= (bits[30:23] == 8'hFF && bits[22:0] != 23'd0) ||
			(!bits[31] && bits[30:23] >= 8'd127);
		zero_s1 <= bits[31] || bits[30:23] < 8'd103;
		man_s1  <= {1'b1, bits[22:0]};
		sh_s1   <= 5'(8'd126 - bits[30:23]);
	end

	logic [31:0] p;
	logic        g;
	logic        s;
	logic        lsb;
	logic [32:0] pr;
	logic [8:0]  t;
	logic [7:0]  res;

	// Product v*255 = (v<<8)-v, rounded to a single, then truncated
	always_comb begin
		p = {man_s1, 8'd0} - {8'd0, man_s1};
		// p lies in [2^30, 2^32): keep 24 significant bits, round to nearest even
		if (p[31]) begin
			lsb = p[8];
			g   = p[7];
			s   = |p[6:0];
			pr  = {1'b0, p[31:8], 8'd0} + (33'(g && (s || lsb)) << 8);
		end else begin
			lsb = p[7];
			g   = p[6];
			s   = |p[5:0];
			pr  = {1'b0, p[31:7], 7'd0} + (33'(g && (s || lsb)) << 7);
		end
		// value*255 = pr * 2^-(24+sh_s1); keep the integer part
		t = 9'(pr >> (6'd24 + {1'b0, sh_s1}));
		res = 8'd0;
		if (sat_s1) begin
			res = 8'hFF;
		end else if (zero_s1) begin
			res = 8'd0;
		end else if (t[8]) begin
			res = 8'hFF;
		end else begin
			res = t[7:0];
		end
	end

	always_ff @(posedge clk) begin
		byte_s2 <= res;
	end

endmodule

FILE: test/testbench.sv
// Testbench for pixel_format_converter: directed table, then random items checked by a predictor.
`timescale 1ns / 1ps
module testbench;

	typedef struct {
		logic [31:0] ch [4];
		logic        status;
		logic        last;
	} pixel_t;

	typedef struct {
		logic [2:0]  src;
		logic [2:0]  dst;
		logic [31:0] ch [4];
		logic        last;
		bit          typed;
		pixel_t      want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] in_ch0 = '0, in_ch1 = '0, in_ch2 = '0, in_ch3 = '0;
	logic        in_last = 1'b0;
	logic        done;
	logic [31:0] out_ch0, out_ch1, out_ch2, out_ch3;
	logic        out_status, out_last;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic [2:0]  src_fmt = pfc_pkg::FMT_RGBA8;
	logic [2:0]  dst_fmt = pfc_pkg::FMT_RGBA8;
	pixel_t      pending_pixels [$];
	row_t        rows [$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          results_seen = 0;

	pixel_format_converter uut (.*);

	always #2 clk = ~clk;

	// Clamp a single to [0,1], scale by 255 in single precision, truncate
	function automatic logic [7:0] unit_to_byte(input logic [31:0] bits);
		logic [63:0] p, keep, rem, half;
		int          k, sh, s;
		if (bits[30:23] == 8'hFF && bits[22:0] != 0) return 8'd255;
		if (bits[31]) return 8'd0;
		if (bits[30:23] >= 8'd127) return 8'd255;
		if (bits[30:23] == 8'd0) return 8'd0;
		p = {40'd0, 1'b1, bits[22:0]} * 64'd255;
		k = 0;
		for (int i = 0; i < 64; i++)
			if (p[i]) k = i;
		// Round the product to 24 significant bits, ties to even
		if (k > 23) begin
			sh = k - 23;
			keep = p >> sh;
			rem = p & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
			p = keep << sh;
		end
		s = 150 - int'(bits[30:23]);
		return (s >= 64) ? 8'd0 : 8'(p >> s);
	endfunction

	// b/255 rounded to nearest single
	function automatic logic [31:0] byte_to_unit(input logic [7:0] b);
		logic [63:0] num, m25, rem, m;
		int          s, ex;
		if (b == 8'd0) return 32'd0;
		s = 0;
		while (({56'd0, b} << s) < (64'd255 << 23)) s++;
		num = {56'd0, b} << (s + 1);
		m25 = num / 255;
		rem = num % 255;
		m = m25 >> 1;
		if (m25[0] && (rem != 0 || m[0])) m = m + 64'd1;
		ex = 150 - s;
		if (m[24]) begin
			m = m >> 1;
			ex++;
		end
		return {1'b0, 8'(ex), m[22:0]};
	endfunction

	// Mask raw channels to the widths a format uses
	function automatic void mask_channels(input logic [2:0] f, input logic [31:0] c [4],
		output logic [31:0] o [4]);
		for (int i = 0; i < 4; i++) o[i] = '0;
		case (f)
			pfc_pkg::FMT_RGBA8, pfc_pkg::FMT_BGRA8:
				for (int i = 0; i < 4; i++) o[i] = {24'd0, c[i][7:0]};
			pfc_pkg::FMT_RGB8, pfc_pkg::FMT_BGR8:
				for (int i = 0; i < 3; i++) o[i] = {24'd0, c[i][7:0]};
			pfc_pkg::FMT_RGB565: o[0] = {16'd0, c[0][15:0]};
			pfc_pkg::FMT_FLOAT: for (int i = 0; i < 4; i++) o[i] = c[i];
			default: ;
		endcase
	endfunction

	// Work out the converted pixel under the current formats
	function automatic pixel_t convert_pixel(input logic [2:0] sf, input logic [2:0] df,
		input logic [31:0] c [4], input logic last);
		pixel_t      r;
		logic [31:0] m [4];
		logic [7:0]  rgba [4];
		logic [4:0]  r5, b5;
		logic [5:0]  g6;
		for (int i = 0; i < 4; i++) r.ch[i] = '0;
		r.status = 1'b0;
		r.last = last;
		if (sf > pfc_pkg::FMT_FLOAT || df > pfc_pkg::FMT_FLOAT) begin
			r.status = 1'b1;
		end else if (sf == df) begin
			mask_channels(sf, c, r.ch);
		end else if (sf == pfc_pkg::FMT_BGR8 || df == pfc_pkg::FMT_BGR8 ||
			(sf == pfc_pkg::FMT_BGRA8 && df != pfc_pkg::FMT_RGBA8)) begin
			r.status = 1'b1;
		end else begin
			mask_channels(sf, c, m);
			case (sf)
				pfc_pkg::FMT_RGBA8: for (int i = 0; i < 4; i++) rgba[i] = m[i][7:0];
				pfc_pkg::FMT_BGRA8: begin
					rgba[0] = m[2][7:0]; rgba[1] = m[1][7:0];
					rgba[2] = m[0][7:0]; rgba[3] = m[3][7:0];
				end
				pfc_pkg::FMT_RGB8: begin
					for (int i = 0; i < 3; i++) rgba[i] = m[i][7:0];
					rgba[3] = 8'd255;
				end
				pfc_pkg::FMT_RGB565: begin
					r5 = m[0][15:11]; g6 = m[0][10:5]; b5 = m[0][4:0];
					rgba[0] = {r5, r5[4:2]};
					rgba[1] = {g6, g6[5:4]};
					rgba[2] = {b5, b5[4:2]};
					rgba[3] = 8'd255;
				end
				default: for (int i = 0; i < 4; i++) rgba[i] = unit_to_byte(m[i]);
			endcase
			case (df)
				pfc_pkg::FMT_RGBA8: for (int i = 0; i < 4; i++) r.ch[i] = {24'd0, rgba[i]};
				pfc_pkg::FMT_BGRA8: begin
					r.ch[0] = {24'd0, rgba[2]}; r.ch[1] = {24'd0, rgba[1]};
					r.ch[2] = {24'd0, rgba[0]}; r.ch[3] = {24'd0, rgba[3]};
				end
				pfc_pkg::FMT_RGB8: for (int i = 0; i < 3; i++) r.ch[i] = {24'd0, rgba[i]};
				pfc_pkg::FMT_RGB565:
					r.ch[0] = {16'd0, rgba[0][7:3], rgba[1][7:2], rgba[2][7:3]};
				default: for (int i = 0; i < 4; i++) r.ch[i] = byte_to_unit(rgba[i]);
			endcase
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
		mismatches++;
	endtask

	// Compare each result strobe with the oldest pending pixel
	always @(posedge clk) begin
		pixel_t w;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				report("unexpected result", 32'd0, 32'd0);
			end else begin
				w = pending_pixels.pop_front();
				if (out_ch0 !== w.ch[0]) report("out_ch0", out_ch0, w.ch[0]);
				if (out_ch1 !== w.ch[1]) report("out_ch1", out_ch1, w.ch[1]);
				if (out_ch2 !== w.ch[2]) report("out_ch2", out_ch2, w.ch[2]);
				if (out_ch3 !== w.ch[3]) report("out_ch3", out_ch3, w.ch[3]);
				if (out_status !== w.status)
					report("out_status", {31'd0, out_status}, {31'd0, w.status});
				if (out_last !== w.last)
					report("out_last", {31'd0, out_last}, {31'd0, w.last});
			end
			results_seen++;
		end
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Let the pipeline empty, then load both formats
	task automatic set_formats(input logic [2:0] sf, input logic [2:0] df);
		start <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		reg_write(pfc_pkg::ADDR_SRC, {29'd0, sf});
		reg_write(pfc_pkg::ADDR_DST, {29'd0, df});
		src_fmt = sf;
		dst_fmt = df;
		@(posedge clk);
	endtask

	// Present one item, hold until accepted, record what it should give
	task automatic send_pixel(input logic [31:0] c [4], input logic last, input bit idle_ok,
		input bit typed, input pixel_t want);
		while (idle_ok && $urandom_range(99) < 30) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		in_ch0 <= c[0]; in_ch1 <= c[1]; in_ch2 <= c[2]; in_ch3 <= c[3]; in_last <= last;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_pixels.push_back(typed ? want : convert_pixel(src_fmt, dst_fmt, c, last));
		items_sent++;
	endtask

	task automatic add_row(input logic [2:0] sf, input logic [2:0] df, input logic [31:0] a,
		input logic [31:0] b, input logic [31:0] c, input logic [31:0] d, input logic last,
		input bit typed, input logic [31:0] w0 = 0, input logic [31:0] w1 = 0,
		input logic [31:0] w2 = 0, input logic [31:0] w3 = 0, input logic ws = 0);
		row_t r;
		r.src = sf; r.dst = df; r.last = last; r.typed = typed;
		r.ch[0] = a; r.ch[1] = b; r.ch[2] = c; r.ch[3] = d;
		r.want.ch[0] = w0; r.want.ch[1] = w1; r.want.ch[2] = w2; r.want.ch[3] = w3;
		r.want.status = ws; r.want.last = last;
		rows.push_back(r);
	endtask

	// Random float channel, biased toward clamp edges and the open unit range
	function automatic logic [31:0] rand_float();
		case ($urandom_range(9))
			0: return 32'h7FC0_0000 | {1'($urandom_range(1)), 31'd0} |
				$urandom_range(32'h3F_FFFF);
			1: return {1'($urandom_range(1)), 31'd0};
			2: return 32'h3F80_0000;
			3: return {1'b0, 8'($urandom_range(254, 127)), 23'($urandom())};
			4: return {1'b1, 31'($urandom())};
			5: return {9'd0, 23'($urandom())};
			6: return $urandom();
			default: return {1'b0, 8'($urandom_range(126, 110)), 23'($urandom())};
		endcase
	endfunction

	initial begin
		logic [31:0] c [4];
		logic [2:0]  sf, df;
		pixel_t      none;
		row_t        r;
		for (int i = 0; i < 4; i++) none.ch[i] = '0;
		none.status = 1'b0; none.last = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; the first runs on the reset formats
		add_row(pfc_pkg::FMT_RGBA8, pfc_pkg::FMT_RGBA8, '1, '1, '1, '1, 1, 1,
			32'hFF, 32'hFF, 32'hFF, 32'hFF);
		add_row(pfc_pkg::FMT_RGBA8, pfc_pkg::FMT_RGBA8, 0, 0, 0, 0, 0, 1);
		add_row(pfc_pkg::FMT_RGB565, pfc_pkg::FMT_RGB565, '1, '1, '1, '1, 1, 1, 32'hFFFF);
		add_row(pfc_pkg::FMT_RGB565, pfc_pkg::FMT_RGBA8, 32'hFFFF, 0, 0, 0, 0, 1,
			32'hFF, 32'hFF, 32'hFF, 32'hFF);
		add_row(pfc_pkg::FMT_RGB565, pfc_pkg::FMT_RGBA8, 32'hFFFF_0000, '1, '1, '1, 1, 1,
			0, 0, 0, 32'hFF);
		add_row(pfc_pkg::FMT_RGBA8, pfc_pkg::FMT_RGB565, '1, '1, '1, '1, 0, 1, 32'hFFFF);
		add_row(pfc_pkg::FMT_BGR8, pfc_pkg::FMT_BGR8, '1, '1, '1, '1, 1, 1,
			32'hFF, 32'hFF, 32'hFF, 0);
		add_row(pfc_pkg::FMT_BGR8, pfc_pkg::FMT_RGBA8, '1, '1, '1, '1, 0, 1, 0, 0, 0, 0, 1);
		add_row(pfc_pkg::FMT_RGBA8, pfc_pkg::FMT_BGR8, '1, '1, '1, '1, 1, 1, 0, 0, 0, 0, 1);
		add_row(pfc_pkg::FMT_BGRA8, pfc_pkg::FMT_RGB8, '1, '1, '1, '1, 0, 1, 0, 0, 0, 0, 1);
		add_row(pfc_pkg::FMT_BGRA8, pfc_pkg::FMT_RGBA8, 32'h11, 32'h22, 32'h33, 32'h44, 1, 0);
		add_row(pfc_pkg::FMT_RGBA8, pfc_pkg::FMT_BGRA8, 32'h11, 32'h22, 32'h33, 32'h44, 0, 0);
		add_row(pfc_pkg::FMT_RGB8, pfc_pkg::FMT_RGBA8, 32'hA5, 32'h5A, 32'hFF, 32'h77, 1, 0);
		add_row(pfc_pkg::FMT_RGBA8, pfc_pkg::FMT_RGB8, 32'hA5, 32'h5A, 32'hFF, 32'h77, 0, 0);
		// Float clamp: NaN, negative zero, above one, one half
		add_row(pfc_pkg::FMT_FLOAT, pfc_pkg::FMT_RGBA8, 32'h7FC0_0000, 32'h8000_0000,
			32'h4000_0000, 32'h3F00_0000, 1, 1, 32'hFF, 0, 32'hFF, 32'd127);
		add_row(pfc_pkg::FMT_FLOAT, pfc_pkg::FMT_RGBA8, 32'h0000_0001, 32'h3F7F_FFFF,
			32'hFF7F_FFFF, 32'h3F80_0000, 0, 0);
		add_row(pfc_pkg::FMT_RGBA8, pfc_pkg::FMT_FLOAT, 0, 32'hFF, 1, 32'h80, 1, 0);
		add_row(pfc_pkg::FMT_FLOAT, pfc_pkg::FMT_FLOAT, '1, 0, 32'h8000_0000, 32'h7F80_0000,
			0, 1, '1, 0, 32'h8000_0000, 32'h7F80_0000);
		add_row(pfc_pkg::FMT_FLOAT, pfc_pkg::FMT_RGB565, 32'h3F80_0000, 32'h3E80_0000,
			32'hBF80_0000, 0, 1, 0);
		add_row(pfc_pkg::FMT_RGB565, pfc_pkg::FMT_FLOAT, 32'h0000_F81F, 0, 0, 0, 0, 0);
		add_row(3'd6, 3'd6, '1, '1, '1, '1, 1, 1, 0, 0, 0, 0, 1);
		add_row(pfc_pkg::FMT_RGBA8, 3'd7, '1, '1, '1, '1, 0, 1, 0, 0, 0, 0, 1);
		add_row(pfc_pkg::FMT_RGB8, pfc_pkg::FMT_RGB8, '1, '1, '1, '1, 1, 1,
			32'hFF, 32'hFF, 32'hFF, 0);

		foreach (rows[i]) begin
			r = rows[i];
			if (i > 0 && (r.src != src_fmt || r.dst != dst_fmt)) set_formats(r.src, r.dst);
			send_pixel(r.ch, r.last, 0, r.typed, r.want);
		end

		// Random items, new format pair every few dozen; one long stretch with no gaps
		for (int n = 0; n < 1500; n++) begin
			if (n % 40 == 0) begin
				sf = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
				df = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
				if ($urandom_range(3) == 0) df = sf;
				set_formats(sf, df);
			end
			for (int i = 0; i < 4; i++)
				c[i] = (src_fmt == pfc_pkg::FMT_FLOAT) ? rand_float() : $urandom();
			send_pixel(c, 1'($urandom_range(1)), !(n >= 600 && n < 800), 0, none);
		end
		start <= 1'b0;

		// Drain and settle
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("covered %0d items, %0d results over random format pairs plus", items_sent,
			results_seen);
		$display("directed clamp, copy, unsupported and undefined-code cases");
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Hard stop if the run hangs
	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
